// ----- design/dsvd_pkg.sv -----
// Shared types, codes and constants of the door state vote debouncer.
package dsvd_pkg;

  // Default window depths.
  localparam int unsigned MODE_WINDOW_DEF   = 10;
  localparam int unsigned SENSOR_WINDOW_DEF = 100;

  // Configuration register widths and reset values.
  localparam int unsigned THRESH_W     = 16;
  localparam int unsigned MODE_MIN_W   = 4;
  localparam int unsigned SENS_MIN_W   = 7;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned DIST_W       = 16;

  localparam logic [THRESH_W-1:0]   THRESH_RST   = 16'd160;
  localparam logic [MODE_MIN_W-1:0] MODE_MIN_RST = 4'd8;
  localparam logic [SENS_MIN_W-1:0] SENS_MIN_RST = 7'd90;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_VOTE_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_VOTE_MIN = 2'd2;

  // Switch mode codes.
  typedef enum logic [1:0] {
    MODE_AUTO   = 2'd0,
    MODE_CLOSED = 2'd1,
    MODE_OPEN   = 2'd2
  } mode_t;

endpackage

// ----- design/dsvd_in_if.sv -----
// Input channel: switch contacts and distance sample.
interface dsvd_in_if;
  import dsvd_pkg::*;

  logic              valid;
  logic              ready;
  logic              contact_a;
  logic              contact_b;
  logic [DIST_W-1:0] distance_q4;

  modport source (output valid, contact_a, contact_b, distance_q4, input ready);
  modport sink   (input valid, contact_a, contact_b, distance_q4, output ready);
endinterface

// ----- design/dsvd_out_if.sv -----
// Result channel: door state, voted mode and voted sensor verdict.
interface dsvd_out_if;
  logic       valid;
  logic       ready;
  logic       door_open;
  logic [1:0] mode;
  logic       sensor_open;

  modport source (output valid, door_open, mode, sensor_open, input ready);
  modport sink   (input valid, door_open, mode, sensor_open, output ready);
endinterface

// ----- design/dsvd_cell.sv -----
// One window entry: a resettable register that loads its input on a shift and holds otherwise.
module dsvd_cell #(
  parameter int unsigned DW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  logic [DW-1:0] d,
  output logic [DW-1:0] q
);
  logic [DW-1:0] q_r;
  logic [DW-1:0] q_nxt;

  always_comb begin
    q_nxt = shift_en ? d : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;
endmodule

// ----- design/dsvd_mode_win.sv -----
// Mode window: chain of cells with running class counts and the mode vote.
module dsvd_mode_win
  import dsvd_pkg::*;
#(
  parameter int unsigned WINDOW = MODE_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  dsvd_pkg::mode_t       sample,
  input  logic [MODE_MIN_W-1:0] vote_min,
  output dsvd_pkg::mode_t       voted_nxt_o
);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned CMP_W = (CNT_W > MODE_MIN_W) ? CNT_W : MODE_MIN_W;

  logic [1:0] tap [WINDOW];
  logic [1:0] oldest;

  logic [CNT_W-1:0] n_auto_r, n_closed_r, n_open_r;
  logic [CNT_W-1:0] n_auto_nxt, n_closed_nxt, n_open_nxt;
  mode_t            voted_r, voted_nxt;

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        dsvd_cell #(.DW(2)) u_cell (
          .clk(clk), .rst_n(rst_n), .shift_en(shift_en), .d(sample), .q(tap[gi])
        );
      end else begin : g_body
        dsvd_cell #(.DW(2)) u_cell (
          .clk(clk), .rst_n(rst_n), .shift_en(shift_en), .d(tap[gi-1]), .q(tap[gi])
        );
      end
    end
  endgenerate

  assign oldest = tap[WINDOW-1];

  always_comb begin
    n_auto_nxt   = n_auto_r   + CNT_W'(sample == MODE_AUTO)
                              - CNT_W'(oldest == MODE_AUTO);
    n_closed_nxt = n_closed_r + CNT_W'(sample == MODE_CLOSED)
                              - CNT_W'(oldest == MODE_CLOSED);
    n_open_nxt   = n_open_r   + CNT_W'((sample != MODE_AUTO) && (sample != MODE_CLOSED))
                              - CNT_W'((oldest != MODE_AUTO) && (oldest != MODE_CLOSED));

    // First qualifying class wins; hold otherwise.
    if (CMP_W'(n_auto_nxt) >= CMP_W'(vote_min)) begin
      voted_nxt = MODE_AUTO;
    end else if (CMP_W'(n_closed_nxt) >= CMP_W'(vote_min)) begin
      voted_nxt = MODE_CLOSED;
    end else if (CMP_W'(n_open_nxt) >= CMP_W'(vote_min)) begin
      voted_nxt = MODE_OPEN;
    end else begin
      voted_nxt = voted_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_auto_r   <= CNT_W'(WINDOW);
      n_closed_r <= '0;
      n_open_r   <= '0;
      voted_r    <= MODE_AUTO;
    end else if (shift_en) begin
      n_auto_r   <= n_auto_nxt;
      n_closed_r <= n_closed_nxt;
      n_open_r   <= n_open_nxt;
      voted_r    <= voted_nxt;
    end
  end

  assign voted_nxt_o = voted_nxt;
endmodule

// ----- design/dsvd_sens_win.sv -----
// Sensor window: chain of one-bit cells with a running presence count and the vote.
module dsvd_sens_win
  import dsvd_pkg::*;
#(
  parameter int unsigned WINDOW = SENSOR_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  logic                  present,
  input  logic [SENS_MIN_W-1:0] vote_min,
  output logic                  voted_nxt_o
);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned CMP_W = (CNT_W > SENS_MIN_W) ? CNT_W : SENS_MIN_W;

  logic             tap [WINDOW];
  logic [CNT_W-1:0] n_open_r, n_open_nxt, n_closed;
  logic             voted_r, voted_nxt;

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        dsvd_cell #(.DW(1)) u_cell (
          .clk(clk), .rst_n(rst_n), .shift_en(shift_en), .d(present), .q(tap[gi])
        );
      end else begin : g_body
        dsvd_cell #(.DW(1)) u_cell (
          .clk(clk), .rst_n(rst_n), .shift_en(shift_en), .d(tap[gi-1]), .q(tap[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    n_open_nxt = n_open_r + CNT_W'(present) - CNT_W'(tap[WINDOW-1]);
    n_closed   = CNT_W'(WINDOW) - n_open_nxt;
    if (CMP_W'(n_open_nxt) >= CMP_W'(vote_min)) begin
      voted_nxt = 1'b1;
    end else if (CMP_W'(n_closed) >= CMP_W'(vote_min)) begin
      voted_nxt = 1'b0;
    end else begin
      voted_nxt = voted_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_open_r <= '0;
      voted_r  <= 1'b0;
    end else if (shift_en) begin
      n_open_r <= n_open_nxt;
      voted_r  <= voted_nxt;
    end
  end

  assign voted_nxt_o = voted_nxt;
endmodule

// ----- design/door_state_vote_debouncer.sv -----
// Door state vote debouncer top level: configuration, windows and result register.
//
// One item is taken every clock cycle unless the output stalls, and its result
// appears in the output register on the next edge; a new item is accepted
// whenever that register is empty or is being taken in the same cycle. Each
// window is a chain of cells that shifts once per transfer, and a running count
// per class (added for the entering sample, subtracted for the sample that drops
// off the end) keeps the vote to an add, a subtract and a compare per class and
// a priority pick. Reset clears all cells at once, so the block is ready in the
// cycle after reset is released. Configuration writes take effect on the next
// transfer and are meant to be made while no transfer is in flight.
module door_state_vote_debouncer
  import dsvd_pkg::*;
#(
  parameter int unsigned MODE_WINDOW   = dsvd_pkg::MODE_WINDOW_DEF,
  parameter int unsigned SENSOR_WINDOW = dsvd_pkg::SENSOR_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dsvd_in_if.sink                         in_ch,
  dsvd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [dsvd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsvd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [THRESH_W-1:0]   near_threshold_r;
  logic [MODE_MIN_W-1:0] mode_vote_min_r;
  logic [SENS_MIN_W-1:0] sensor_vote_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_threshold_r  <= THRESH_RST;
      mode_vote_min_r   <= MODE_MIN_RST;
      sensor_vote_min_r <= SENS_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NEAR_THRESHOLD:  near_threshold_r  <= cfg_wdata[THRESH_W-1:0];
        REG_MODE_VOTE_MIN:   mode_vote_min_r   <= cfg_wdata[MODE_MIN_W-1:0];
        REG_SENSOR_VOTE_MIN: sensor_vote_min_r <= cfg_wdata[SENS_MIN_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Handshake: accept when the result register is free or draining now.
  logic  out_valid_r;
  logic  take;
  mode_t sample_mode;
  logic  present;
  mode_t mode_vote;
  logic  sensor_vote;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  // Decode the switch contacts: a low and b high is auto, both low is
  // manual closed, anything else is manual open.
  always_comb begin
    if (!in_ch.contact_a && in_ch.contact_b) begin
      sample_mode = MODE_AUTO;
    end else if (!in_ch.contact_a && !in_ch.contact_b) begin
      sample_mode = MODE_CLOSED;
    end else begin
      sample_mode = MODE_OPEN;
    end
  end

  // Present when the target is nearer than the threshold.
  assign present = in_ch.distance_q4 < near_threshold_r;

  dsvd_mode_win #(.WINDOW(MODE_WINDOW)) u_mode_win (
    .clk         (clk),
    .rst_n       (rst_n),
    .shift_en    (take),
    .sample      (sample_mode),
    .vote_min    (mode_vote_min_r),
    .voted_nxt_o (mode_vote)
  );

  dsvd_sens_win #(.WINDOW(SENSOR_WINDOW)) u_sens_win (
    .clk         (clk),
    .rst_n       (rst_n),
    .shift_en    (take),
    .present     (present),
    .vote_min    (sensor_vote_min_r),
    .voted_nxt_o (sensor_vote)
  );

  // Result register.
  logic  out_valid_nxt;
  logic  door_r, door_nxt;
  mode_t mode_r;
  logic  sensor_r;

  always_comb begin
    // Auto mode follows the sensor; manual modes force the door.
    if (mode_vote == MODE_AUTO) begin
      door_nxt = sensor_vote;
    end else begin
      door_nxt = (mode_vote == MODE_OPEN);
    end

    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the payload only on a transfer in.
  always_ff @(posedge clk) begin
    if (take) begin
      door_r   <= door_nxt;
      mode_r   <= mode_vote;
      sensor_r <= sensor_vote;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.door_open   = door_r;
  assign out_ch.mode        = mode_r;
  assign out_ch.sensor_open = sensor_r;

endmodule
